// ===== rtl/core/adp_pkg.sv =====
package adp_pkg;

    // Fixed-point formats
    localparam int QUAT_FRAC = 14;
    localparam int RATE_FRAC = 12;
    localparam int COEF_FRAC = 16;
    localparam int OUT_FRAC  = 16;

    localparam int COEF_W = 32;
    localparam int OUT_W  = 32;

    // Right shift of the quaternion sums: product fraction plus the factor one half
    localparam int QSHIFT = QUAT_FRAC + RATE_FRAC + 1 - OUT_FRAC;
    // Gyroscopic term fraction down to the output fraction
    localparam int ESHIFT = COEF_FRAC + 2 * RATE_FRAC - OUT_FRAC;
    // Left shift that lines the torque term up with the gyroscopic term
    localparam int TSHIFT = RATE_FRAC;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_Z = 3'd5;

    localparam logic signed [COEF_W-1:0] INV_RESET  = 32'sh0001_0000;
    localparam logic signed [COEF_W-1:0] GYRO_RESET = 32'sh0000_0000;

    // Width that every signed value is widened to before saturation
    localparam int SAT_W = 128;
    localparam logic signed [SAT_W-1:0] S32_MAX = 128'sh7FFF_FFFF;
    localparam logic signed [SAT_W-1:0] S32_MIN = -128'sh8000_0000;

    // Per-stage load enables of the four-stage pipe
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_stage_en;

    function automatic logic [OUT_W-1:0] sat_s32(input logic signed [SAT_W-1:0] v);
        logic [OUT_W-1:0] res;
        if (v > S32_MAX) begin
            res = 32'h7FFF_FFFF;
        end else if (v < S32_MIN) begin
            res = 32'h8000_0000;
        end else begin
            res = v[OUT_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/adp_kin.sv =====
module adp_kin #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                          i_clk,
    input  adp_pkg::t_stage_en            i_en,
    input  logic signed [DATA_WIDTH-1:0]  i_q0,
    input  logic signed [DATA_WIDTH-1:0]  i_q1,
    input  logic signed [DATA_WIDTH-1:0]  i_q2,
    input  logic signed [DATA_WIDTH-1:0]  i_q3,
    input  logic signed [DATA_WIDTH-1:0]  i_wx,
    input  logic signed [DATA_WIDTH-1:0]  i_wy,
    input  logic signed [DATA_WIDTH-1:0]  i_wz,
    output logic [adp_pkg::OUT_W-1:0]     o_dq0,
    output logic [adp_pkg::OUT_W-1:0]     o_dq1,
    output logic [adp_pkg::OUT_W-1:0]     o_dq2,
    output logic [adp_pkg::OUT_W-1:0]     o_dq3
);
    import adp_pkg::*;

    localparam int PW = 2 * DATA_WIDTH;
    localparam int SW = PW + 2;
    localparam logic signed [SW-1:0] RND = SW'(1 << (QSHIFT - 1));

    logic signed [PW-1:0]    r_prod [12];
    logic signed [SW-1:0]    r_ab   [4];
    logic signed [PW-1:0]    r_c    [4];
    logic signed [SW-1:0]    r_sum  [4];
    logic        [OUT_W-1:0] r_dq   [4];

    // stage 1: all twelve rate-by-quaternion products
    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_prod[0]  <= i_wx * i_q1;
            r_prod[1]  <= i_wy * i_q2;
            r_prod[2]  <= i_wz * i_q3;
            r_prod[3]  <= i_wx * i_q0;
            r_prod[4]  <= i_wz * i_q2;
            r_prod[5]  <= i_wy * i_q3;
            r_prod[6]  <= i_wy * i_q0;
            r_prod[7]  <= i_wz * i_q1;
            r_prod[8]  <= i_wx * i_q3;
            r_prod[9]  <= i_wz * i_q0;
            r_prod[10] <= i_wy * i_q1;
            r_prod[11] <= i_wx * i_q2;
        end
    end

    // stage 2: first two terms of each row
    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_ab[0] <= -SW'(r_prod[0]) - SW'(r_prod[1]);
            r_ab[1] <=  SW'(r_prod[3]) + SW'(r_prod[4]);
            r_ab[2] <=  SW'(r_prod[6]) - SW'(r_prod[7]);
            r_ab[3] <=  SW'(r_prod[9]) + SW'(r_prod[10]);
            r_c[0]  <= r_prod[2];
            r_c[1]  <= r_prod[5];
            r_c[2]  <= r_prod[8];
            r_c[3]  <= r_prod[11];
        end
    end

    // stage 3: third term plus rounding half
    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_sum[0] <= r_ab[0] - SW'(r_c[0]) + RND;
            r_sum[1] <= r_ab[1] - SW'(r_c[1]) + RND;
            r_sum[2] <= r_ab[2] + SW'(r_c[2]) + RND;
            r_sum[3] <= r_ab[3] - SW'(r_c[3]) + RND;
        end
    end

    // stage 4: floor shift and saturate
    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            for (int n = 0; n < 4; n++) begin
                r_dq[n] <= sat_s32(SAT_W'(r_sum[n] >>> QSHIFT));
            end
        end
    end

    assign o_dq0 = r_dq[0];
    assign o_dq1 = r_dq[1];
    assign o_dq2 = r_dq[2];
    assign o_dq3 = r_dq[3];

endmodule

// ===== rtl/core/adp_euler.sv =====
module adp_euler #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                              i_clk,
    input  adp_pkg::t_stage_en                i_en,
    input  logic signed [adp_pkg::COEF_W-1:0] i_gyro,
    input  logic signed [adp_pkg::COEF_W-1:0] i_inv,
    input  logic signed [DATA_WIDTH-1:0]      i_wa,
    input  logic signed [DATA_WIDTH-1:0]      i_wb,
    input  logic signed [DATA_WIDTH-1:0]      i_tq,
    output logic [adp_pkg::OUT_W-1:0]         o_accel
);
    import adp_pkg::*;

    localparam int PW = 2 * DATA_WIDTH;
    localparam int GW = COEF_W + PW;
    localparam int TW = COEF_W + DATA_WIDTH + TSHIFT;
    localparam int AW = ((GW > TW) ? GW : TW) + 2;
    localparam logic signed [AW-1:0] RND = AW'(1 << (ESHIFT - 1));

    logic signed [PW-1:0]                  r_ww;
    logic signed [COEF_W+DATA_WIDTH-1:0]   r_t1;
    logic signed [COEF_W+DATA_WIDTH-1:0]   r_gh;
    logic signed [COEF_W+DATA_WIDTH:0]     r_gl;
    logic signed [COEF_W+DATA_WIDTH-1:0]   r_t2;
    logic signed [AW-1:0]                  r_sum;
    logic        [OUT_W-1:0]               r_acc;

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_ww <= i_wa * i_wb;
            r_t1 <= i_inv * i_tq;
        end
    end

    // rate product split in halves so each multiply stays coefficient by one word
    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_gh <= i_gyro * $signed(r_ww[PW-1:DATA_WIDTH]);
            r_gl <= i_gyro * $signed({1'b0, r_ww[DATA_WIDTH-1:0]});
            r_t2 <= r_t1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_sum <= (AW'(r_gh) <<< DATA_WIDTH) + AW'(r_gl) + (AW'(r_t2) <<< TSHIFT) + RND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_acc <= sat_s32(SAT_W'(r_sum >>> ESHIFT));
        end
    end

    assign o_accel = r_acc;

endmodule

// ===== rtl/core/adp_norm.sv =====
module adp_norm #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                          i_clk,
    input  adp_pkg::t_stage_en            i_en,
    input  logic signed [DATA_WIDTH-1:0]  i_q0,
    input  logic signed [DATA_WIDTH-1:0]  i_q1,
    input  logic signed [DATA_WIDTH-1:0]  i_q2,
    input  logic signed [DATA_WIDTH-1:0]  i_q3,
    output logic [adp_pkg::OUT_W-1:0]     o_norm
);
    import adp_pkg::*;

    localparam int PW = 2 * DATA_WIDTH;
    localparam int NW = PW + 2;
    localparam int CW = NW + OUT_W;
    localparam logic [CW-1:0] NORM_MAX = CW'(32'hFFFF_FFFF);

    logic [PW-1:0]    r_sq   [4];
    logic [PW:0]      r_pair [2];
    logic [NW-1:0]    r_tot;
    logic [OUT_W-1:0] r_norm;
    logic [CW-1:0]    tot_ext;

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_sq[0] <= i_q0 * i_q0;
            r_sq[1] <= i_q1 * i_q1;
            r_sq[2] <= i_q2 * i_q2;
            r_sq[3] <= i_q3 * i_q3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_pair[0] <= (PW + 1)'(r_sq[0]) + (PW + 1)'(r_sq[1]);
            r_pair[1] <= (PW + 1)'(r_sq[2]) + (PW + 1)'(r_sq[3]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_tot <= NW'(r_pair[0]) + NW'(r_pair[1]);
        end
    end

    assign tot_ext = CW'(r_tot);

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_norm <= (tot_ext > NORM_MAX) ? 32'hFFFF_FFFF : tot_ext[OUT_W-1:0];
        end
    end

    assign o_norm = r_norm;

endmodule

// ===== rtl/core/attitude_dynamics_derivative.sv =====
// Rigid-body attitude derivative: each item (quaternion in Q1.14, body rates and
// torques in Q3.12) yields the four quaternion rates 0.5*Omega(w)*q, the three Euler
// angular accelerations gyro_coef*wa*wb + inv_inertia*torque (all saturating Q15.16)
// and the squared quaternion norm (unsigned Q4.28, clamped at all ones). The datapath
// is a four-stage pipe: multiply, partial sum, final sum with rounding, shift and
// saturate. One item is taken every cycle while o_stall is low; o_stall rises only
// when the output stage holds an untaken result and every stage behind it is full.
// Configuration registers (index 0..5: inv_inertia_x/y/z, gyro_coef_x/y/z, signed
// Q16.16) are always ready and must be written while the pipe is empty; other
// indexes are ignored.
module attitude_dynamics_derivative #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [DATA_WIDTH-1:0]       i_quat_scalar,
    input  logic signed [DATA_WIDTH-1:0]       i_quat_i,
    input  logic signed [DATA_WIDTH-1:0]       i_quat_j,
    input  logic signed [DATA_WIDTH-1:0]       i_quat_k,
    input  logic signed [DATA_WIDTH-1:0]       i_rate_x,
    input  logic signed [DATA_WIDTH-1:0]       i_rate_y,
    input  logic signed [DATA_WIDTH-1:0]       i_rate_z,
    input  logic signed [DATA_WIDTH-1:0]       i_torque_x,
    input  logic signed [DATA_WIDTH-1:0]       i_torque_y,
    input  logic signed [DATA_WIDTH-1:0]       i_torque_z,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [adp_pkg::OUT_W-1:0]   o_dquat_scalar,
    output logic signed [adp_pkg::OUT_W-1:0]   o_dquat_i,
    output logic signed [adp_pkg::OUT_W-1:0]   o_dquat_j,
    output logic signed [adp_pkg::OUT_W-1:0]   o_dquat_k,
    output logic signed [adp_pkg::OUT_W-1:0]   o_accel_x,
    output logic signed [adp_pkg::OUT_W-1:0]   o_accel_y,
    output logic signed [adp_pkg::OUT_W-1:0]   o_accel_z,
    output logic [adp_pkg::OUT_W-1:0]          o_norm_squared,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [adp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [adp_pkg::COEF_W-1:0]         i_cfg_data
);
    import adp_pkg::*;

    logic signed [COEF_W-1:0] r_inv_x, r_inv_y, r_inv_z;
    logic signed [COEF_W-1:0] r_gyro_x, r_gyro_y, r_gyro_z;
    logic        [3:0]        r_vld;
    t_stage_en                en;

    logic [OUT_W-1:0] dq0, dq1, dq2, dq3, ax, ay, az, nrm;

    // a stage loads when it is empty or the stage ahead moves on
    always_comb begin
        en.s4 = !r_vld[3] || !i_stall;
        en.s3 = !r_vld[2] || en.s4;
        en.s2 = !r_vld[1] || en.s3;
        en.s1 = !r_vld[0] || en.s2;
    end

    assign o_stall = !en.s1;
    assign o_valid = r_vld[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en.s1) r_vld[0] <= i_valid;
            if (en.s2) r_vld[1] <= r_vld[0];
            if (en.s3) r_vld[2] <= r_vld[1];
            if (en.s4) r_vld[3] <= r_vld[2];
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_x  <= INV_RESET;
            r_inv_y  <= INV_RESET;
            r_inv_z  <= INV_RESET;
            r_gyro_x <= GYRO_RESET;
            r_gyro_y <= GYRO_RESET;
            r_gyro_z <= GYRO_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_INV_X:  r_inv_x  <= $signed(i_cfg_data);
                CFG_INV_Y:  r_inv_y  <= $signed(i_cfg_data);
                CFG_INV_Z:  r_inv_z  <= $signed(i_cfg_data);
                CFG_GYRO_X: r_gyro_x <= $signed(i_cfg_data);
                CFG_GYRO_Y: r_gyro_y <= $signed(i_cfg_data);
                CFG_GYRO_Z: r_gyro_z <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    adp_kin #(.DATA_WIDTH(DATA_WIDTH)) u_kin (
        .i_clk (i_clk),
        .i_en  (en),
        .i_q0  (i_quat_scalar),
        .i_q1  (i_quat_i),
        .i_q2  (i_quat_j),
        .i_q3  (i_quat_k),
        .i_wx  (i_rate_x),
        .i_wy  (i_rate_y),
        .i_wz  (i_rate_z),
        .o_dq0 (dq0),
        .o_dq1 (dq1),
        .o_dq2 (dq2),
        .o_dq3 (dq3)
    );

    adp_euler #(.DATA_WIDTH(DATA_WIDTH)) u_euler_x (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_gyro  (r_gyro_x),
        .i_inv   (r_inv_x),
        .i_wa    (i_rate_y),
        .i_wb    (i_rate_z),
        .i_tq    (i_torque_x),
        .o_accel (ax)
    );

    adp_euler #(.DATA_WIDTH(DATA_WIDTH)) u_euler_y (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_gyro  (r_gyro_y),
        .i_inv   (r_inv_y),
        .i_wa    (i_rate_z),
        .i_wb    (i_rate_x),
        .i_tq    (i_torque_y),
        .o_accel (ay)
    );

    adp_euler #(.DATA_WIDTH(DATA_WIDTH)) u_euler_z (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_gyro  (r_gyro_z),
        .i_inv   (r_inv_z),
        .i_wa    (i_rate_x),
        .i_wb    (i_rate_y),
        .i_tq    (i_torque_z),
        .o_accel (az)
    );

    adp_norm #(.DATA_WIDTH(DATA_WIDTH)) u_norm (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_q0   (i_quat_scalar),
        .i_q1   (i_quat_i),
        .i_q2   (i_quat_j),
        .i_q3   (i_quat_k),
        .o_norm (nrm)
    );

    assign o_dquat_scalar = $signed(dq0);
    assign o_dquat_i      = $signed(dq1);
    assign o_dquat_j      = $signed(dq2);
    assign o_dquat_k      = $signed(dq3);
    assign o_accel_x      = $signed(ax);
    assign o_accel_y      = $signed(ay);
    assign o_accel_z      = $signed(az);
    assign o_norm_squared = nrm;

endmodule

// ===== bench/attitude_dynamics_derivative_tb.sv =====
`timescale 1ns / 1ps

module attitude_dynamics_derivative_tb;
    import adp_pkg::*;

    localparam int FIELD_W       = 16;
    localparam int QUAT_DROP     = QUAT_FRAC + RATE_FRAC + 1 - OUT_FRAC;
    localparam int ACCEL_DROP    = COEF_FRAC + 2 * RATE_FRAC - OUT_FRAC;
    localparam int TORQUE_ALIGN  = RATE_FRAC;
    localparam int PIPE_TAIL     = 8;
    localparam int WATCHDOG_MAX  = 3000;
    localparam int NUM_COEFS     = 6;

    localparam logic signed [FIELD_W-1:0] F_MAX = 16'sh7FFF;
    localparam logic signed [FIELD_W-1:0] F_MIN = 16'sh8000;
    localparam logic signed [FIELD_W-1:0] Q_ONE = 16'sh4000;
    localparam logic [COEF_W-1:0] C_MAX = 32'h7FFF_FFFF;
    localparam logic [COEF_W-1:0] C_MIN = 32'h8000_0000;

    typedef struct packed {
        logic signed [FIELD_W-1:0] quat_scalar;
        logic signed [FIELD_W-1:0] quat_i;
        logic signed [FIELD_W-1:0] quat_j;
        logic signed [FIELD_W-1:0] quat_k;
        logic signed [FIELD_W-1:0] rate_x;
        logic signed [FIELD_W-1:0] rate_y;
        logic signed [FIELD_W-1:0] rate_z;
        logic signed [FIELD_W-1:0] torque_x;
        logic signed [FIELD_W-1:0] torque_y;
        logic signed [FIELD_W-1:0] torque_z;
    } t_att_item;

    typedef struct packed {
        logic [OUT_W-1:0] dquat_scalar;
        logic [OUT_W-1:0] dquat_i;
        logic [OUT_W-1:0] dquat_j;
        logic [OUT_W-1:0] dquat_k;
        logic [OUT_W-1:0] accel_x;
        logic [OUT_W-1:0] accel_y;
        logic [OUT_W-1:0] accel_z;
        logic [OUT_W-1:0] norm_squared;
    } t_deriv;

    typedef enum {SINK_NONE, SINK_RANDOM, SINK_PERIODIC, SINK_HEAVY} t_sink_mode;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [FIELD_W-1:0] i_quat_scalar = '0;
    logic signed [FIELD_W-1:0] i_quat_i = '0;
    logic signed [FIELD_W-1:0] i_quat_j = '0;
    logic signed [FIELD_W-1:0] i_quat_k = '0;
    logic signed [FIELD_W-1:0] i_rate_x = '0;
    logic signed [FIELD_W-1:0] i_rate_y = '0;
    logic signed [FIELD_W-1:0] i_rate_z = '0;
    logic signed [FIELD_W-1:0] i_torque_x = '0;
    logic signed [FIELD_W-1:0] i_torque_y = '0;
    logic signed [FIELD_W-1:0] i_torque_z = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [OUT_W-1:0] o_dquat_scalar;
    logic signed [OUT_W-1:0] o_dquat_i;
    logic signed [OUT_W-1:0] o_dquat_j;
    logic signed [OUT_W-1:0] o_dquat_k;
    logic signed [OUT_W-1:0] o_accel_x;
    logic signed [OUT_W-1:0] o_accel_y;
    logic signed [OUT_W-1:0] o_accel_z;
    logic [OUT_W-1:0] o_norm_squared;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [COEF_W-1:0] i_cfg_data = '0;

    // predictor copy of the coefficient registers
    logic signed [COEF_W-1:0] coef_reg [NUM_COEFS];

    t_att_item pending_items[$];
    t_deriv expected_derivs[$];
    t_att_item next_item;

    int pushed_cnt = 0;
    int accept_cnt = 0;
    int issue_cnt = 0;
    int result_cnt = 0;
    int error_cnt = 0;
    int reg_write_cnt = 0;
    int idle_cycles = 0;
    int gap_left = 0;
    int burst_left = 0;
    int burst_max = 8;
    int gap_max = 4;
    int sink_cycle = 0;
    t_sink_mode sink_mode = SINK_NONE;

    attitude_dynamics_derivative uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_quat_scalar  (i_quat_scalar),
        .i_quat_i       (i_quat_i),
        .i_quat_j       (i_quat_j),
        .i_quat_k       (i_quat_k),
        .i_rate_x       (i_rate_x),
        .i_rate_y       (i_rate_y),
        .i_rate_z       (i_rate_z),
        .i_torque_x     (i_torque_x),
        .i_torque_y     (i_torque_y),
        .i_torque_z     (i_torque_z),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_dquat_scalar (o_dquat_scalar),
        .o_dquat_i      (o_dquat_i),
        .o_dquat_j      (o_dquat_j),
        .o_dquat_k      (o_dquat_k),
        .o_accel_x      (o_accel_x),
        .o_accel_y      (o_accel_y),
        .o_accel_z      (o_accel_z),
        .o_norm_squared (o_norm_squared),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // round half up at the dropped bits, then clamp to signed 32 bits
    function automatic logic [OUT_W-1:0] round_clamp(input logic signed [127:0] v,
                                                      input int drop);
        logic signed [127:0] s;
        s = (v + (128'sd1 <<< (drop - 1))) >>> drop;
        if (s > 128'sh7FFF_FFFF) return 32'h7FFF_FFFF;
        if (s < -128'sh8000_0000) return 32'h8000_0000;
        return s[OUT_W-1:0];
    endfunction

    function automatic t_deriv predict_derivative(input t_att_item it);
        logic signed [127:0] q0, q1, q2, q3, wx, wy, wz, tx, ty, tz;
        logic signed [127:0] ix, iy, iz, gx, gy, gz;
        logic [127:0] nrm;
        t_deriv r;
        q0 = it.quat_scalar;
        q1 = it.quat_i;
        q2 = it.quat_j;
        q3 = it.quat_k;
        wx = it.rate_x;
        wy = it.rate_y;
        wz = it.rate_z;
        tx = it.torque_x;
        ty = it.torque_y;
        tz = it.torque_z;
        ix = coef_reg[CFG_INV_X];
        iy = coef_reg[CFG_INV_Y];
        iz = coef_reg[CFG_INV_Z];
        gx = coef_reg[CFG_GYRO_X];
        gy = coef_reg[CFG_GYRO_Y];
        gz = coef_reg[CFG_GYRO_Z];
        r.dquat_scalar = round_clamp(-(wx * q1) - wy * q2 - wz * q3, QUAT_DROP);
        r.dquat_i      = round_clamp(wx * q0 + wz * q2 - wy * q3, QUAT_DROP);
        r.dquat_j      = round_clamp(wy * q0 - wz * q1 + wx * q3, QUAT_DROP);
        r.dquat_k      = round_clamp(wz * q0 + wy * q1 - wx * q2, QUAT_DROP);
        r.accel_x = round_clamp(gx * wy * wz + ix * (tx <<< TORQUE_ALIGN), ACCEL_DROP);
        r.accel_y = round_clamp(gy * wz * wx + iy * (ty <<< TORQUE_ALIGN), ACCEL_DROP);
        r.accel_z = round_clamp(gz * wx * wy + iz * (tz <<< TORQUE_ALIGN), ACCEL_DROP);
        nrm = q0 * q0 + q1 * q1 + q2 * q2 + q3 * q3;
        r.norm_squared = (nrm > 128'hFFFF_FFFF) ? '1 : nrm[OUT_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [OUT_W-1:0] exp_v,
                               input logic [OUT_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
            error_cnt++;
        end
    endtask

    // sender: bursts of random length separated by random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || accept_cnt == issue_cnt) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                i_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                next_item = pending_items.pop_front();
                i_quat_scalar <= next_item.quat_scalar;
                i_quat_i      <= next_item.quat_i;
                i_quat_j      <= next_item.quat_j;
                i_quat_k      <= next_item.quat_k;
                i_rate_x      <= next_item.rate_x;
                i_rate_y      <= next_item.rate_y;
                i_rate_z      <= next_item.rate_z;
                i_torque_x    <= next_item.torque_x;
                i_torque_y    <= next_item.torque_y;
                i_torque_z    <= next_item.torque_z;
                i_valid       <= 1'b1;
                issue_cnt     <= issue_cnt + 1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, burst_max);
                    gap_left = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                end else begin
                    burst_left = burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        sink_cycle = sink_cycle + 1;
        case (sink_mode)
            SINK_NONE:     i_stall <= 1'b0;
            SINK_RANDOM:   i_stall <= ($urandom_range(0, 99) < 30);
            SINK_PERIODIC: i_stall <= ((sink_cycle % 23) < 7);
            default:       i_stall <= ($urandom_range(0, 99) < 70);
        endcase
    end

    always @(posedge i_clk) begin
        t_deriv exp_r;
        t_deriv act_r;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                expected_derivs.push_back(predict_derivative({i_quat_scalar, i_quat_i,
                    i_quat_j, i_quat_k, i_rate_x, i_rate_y, i_rate_z,
                    i_torque_x, i_torque_y, i_torque_z}));
                accept_cnt <= accept_cnt + 1;
            end
            if (o_valid === 1'b1 && !i_stall) begin
                result_cnt++;
                if (expected_derivs.size() == 0) begin
                    $error("result with no item outstanding");
                    error_cnt++;
                end else begin
                    exp_r = expected_derivs.pop_front();
                    act_r = {o_dquat_scalar, o_dquat_i, o_dquat_j, o_dquat_k,
                             o_accel_x, o_accel_y, o_accel_z, o_norm_squared};
                    check_field("dquat_scalar", exp_r.dquat_scalar, act_r.dquat_scalar);
                    check_field("dquat_i", exp_r.dquat_i, act_r.dquat_i);
                    check_field("dquat_j", exp_r.dquat_j, act_r.dquat_j);
                    check_field("dquat_k", exp_r.dquat_k, act_r.dquat_k);
                    check_field("accel_x", exp_r.accel_x, act_r.accel_x);
                    check_field("accel_y", exp_r.accel_y, act_r.accel_y);
                    check_field("accel_z", exp_r.accel_z, act_r.accel_z);
                    check_field("norm_squared", exp_r.norm_squared, act_r.norm_squared);
                end
            end
        end
    end

    // watchdog: only counts while work is outstanding
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid === 1'b1 && !i_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (pushed_cnt != accept_cnt || expected_derivs.size() != 0) begin
            if (idle_cycles + 1 >= WATCHDOG_MAX) begin
                $display("[attitude_dynamics_derivative] ERROR");
                $finish;
            end
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic add_item(input logic signed [FIELD_W-1:0] q0, q1, q2, q3,
                            input logic signed [FIELD_W-1:0] wx, wy, wz,
                            input logic signed [FIELD_W-1:0] tx, ty, tz);
        pending_items.push_back({q0, q1, q2, q3, wx, wy, wz, tx, ty, tz});
        pushed_cnt++;
    endtask

    // full-range values, biased toward the edges
    function automatic logic signed [FIELD_W-1:0] rand_field();
        case ($urandom_range(0, 11))
            0:       return F_MIN;
            1:       return F_MAX;
            2:       return '0;
            3:       return -16'sd1;
            4:       return 16'sd1;
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    task automatic add_random(input int n);
        repeat (n) begin
            add_item(rand_field(), rand_field(), rand_field(), rand_field(),
                     rand_field(), rand_field(), rand_field(),
                     rand_field(), rand_field(), rand_field());
        end
    endtask

    task automatic set_idling(input int bmax, input int gmax, input t_sink_mode mode);
        burst_max = bmax;
        gap_max = gmax;
        sink_mode = mode;
    endtask

    task automatic wait_drained();
        while (accept_cnt != pushed_cnt || expected_derivs.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_TAIL) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        if (idx <= CFG_GYRO_Z) coef_reg[idx] = val;
        reg_write_cnt++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic program_coefs(input logic [COEF_W-1:0] ix, iy, iz, gx, gy, gz);
        write_reg(CFG_INV_X, ix);
        write_reg(CFG_INV_Y, iy);
        write_reg(CFG_INV_Z, iz);
        write_reg(CFG_GYRO_X, gx);
        write_reg(CFG_GYRO_Y, gy);
        write_reg(CFG_GYRO_Z, gz);
    endtask

    initial begin
        coef_reg[CFG_INV_X]  = INV_RESET;
        coef_reg[CFG_INV_Y]  = INV_RESET;
        coef_reg[CFG_INV_Z]  = INV_RESET;
        coef_reg[CFG_GYRO_X] = GYRO_RESET;
        coef_reg[CFG_GYRO_Y] = GYRO_RESET;
        coef_reg[CFG_GYRO_Z] = GYRO_RESET;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset coefficients: field extremes, norm clamp, quaternion rounding ties
        set_idling(6, 3, SINK_RANDOM);
        add_item('0, '0, '0, '0, '0, '0, '0, '0, '0, '0);
        add_item(F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX);
        add_item(F_MIN, F_MIN, F_MIN, F_MIN, F_MIN, F_MIN, F_MIN, F_MIN, F_MIN, F_MIN);
        add_item(F_MIN, F_MIN, F_MIN, F_MIN, F_MAX, F_MAX, F_MAX, F_MIN, F_MAX, F_MIN);
        add_item(F_MAX, F_MIN, F_MAX, F_MIN, F_MIN, F_MAX, F_MIN, F_MAX, F_MIN, F_MAX);
        add_item(F_MIN, F_MIN, F_MIN, F_MAX, '0, '0, '0, '0, '0, '0);
        add_item(-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1,
                 -16'sd1, -16'sd1, -16'sd1);
        add_item(16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1,
                 16'sd1, 16'sd1, 16'sd1);
        add_item(Q_ONE, '0, '0, '0, 16'sd4096, -16'sd4096, 16'sd2048,
                 16'sd4096, '0, -16'sd4096);
        // half an output LSB in each direction
        add_item('0, 16'sd1024, '0, '0, -16'sd1, '0, '0, '0, '0, '0);
        add_item('0, 16'sd1024, '0, '0, 16'sd1, '0, '0, '0, '0, '0);
        add_item(16'sd1024, '0, '0, '0, '0, 16'sd1, -16'sd1, '0, '0, '0);
        add_random(150);
        wait_drained();

        // max reciprocals, most negative gyro terms: accelerations saturate
        program_coefs(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN);
        set_idling(10, 5, SINK_PERIODIC);
        add_item(F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX);
        add_item(F_MIN, F_MIN, F_MIN, F_MIN, F_MIN, F_MIN, F_MIN, F_MIN, F_MIN, F_MIN);
        add_item('0, '0, '0, '0, F_MAX, F_MIN, F_MAX, F_MIN, F_MAX, F_MIN);
        add_item('0, '0, '0, '0, '0, '0, '0, F_MIN, F_MAX, 16'sd1);
        add_random(100);
        wait_drained();

        // opposite extremes; sender holds off mid-phase until the pipe empties
        program_coefs(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
        set_idling(4, 8, SINK_HEAVY);
        add_random(50);
        wait_drained();
        add_random(50);
        wait_drained();

        // smallest nonzero coefficients expose acceleration rounding ties
        program_coefs(32'h1, 32'h1, 32'h1, 32'h1, 32'h1, 32'h1);
        set_idling(16, 2, SINK_RANDOM);
        add_item('0, '0, '0, '0, '0, '0, '0, 16'sd2048, -16'sd2048, 16'sd2048);
        add_item('0, '0, '0, '0, 16'sd4096, 16'sd2048, '0, '0, '0, '0);
        add_item('0, '0, '0, '0, -16'sd4096, 16'sd2048, '0, '0, '0, '0);
        add_item('0, '0, '0, '0, F_MIN, F_MIN, F_MIN, F_MIN, F_MIN, F_MIN);
        add_random(50);
        wait_drained();

        // random coefficients, with writes to unused indexes that must be ignored
        program_coefs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        write_reg(CFG_IDX_W'($urandom_range(CFG_GYRO_Z + 1, 2 ** CFG_IDX_W - 1)), $urandom);
        write_reg('1, $urandom);
        set_idling(20, 6, SINK_PERIODIC);
        add_random(150);
        wait_drained();

        // plausible spacecraft values, back to back with no idling
        program_coefs($urandom_range(32'h8000, 32'h40000), $urandom_range(32'h8000, 32'h40000),
                      $urandom_range(32'h8000, 32'h40000),
                      $urandom_range(0, 32'h20000) - 32'h10000,
                      $urandom_range(0, 32'h20000) - 32'h10000,
                      $urandom_range(0, 32'h20000) - 32'h10000);
        set_idling(1, 0, SINK_NONE);
        add_random(80);
        wait_drained();

        if (expected_derivs.size() != 0) begin
            $error("%0d results never arrived", expected_derivs.size());
            error_cnt++;
        end
        $display("Checked %0d results from %0d items over %0d register writes", result_cnt,
                 accept_cnt, reg_write_cnt);
        $display("Covered saturation at both coefficient extremes, rounding ties, norm clamp");
        if (error_cnt == 0) begin
            $display("[attitude_dynamics_derivative] OK");
        end else begin
            $display("[attitude_dynamics_derivative] ERROR");
        end
        $finish;
    end

endmodule
